@@ rtl/core/tpcdt_pkg.sv @@
// Shared types and constants of the triangle coverage and depth test block
package tpcdt_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int DEPTH_BITS  = 24;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    // Serial divider sizes: widest quotient (reciprocal depth) and widest divisor (term sum)
    localparam int QUO_W  = 41;
    localparam int REM_W  = 58;
    localparam int QCNT_W = 6;

    // Command codes
    localparam logic [1:0] CMD_SETUP  = 2'd0;
    localparam logic [1:0] CMD_PIXEL  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_DEPTH_TEST  = 2'd0;
    localparam logic [1:0] REG_DEPTH_WRITE = 2'd1;
    localparam logic [1:0] REG_WIDTH       = 2'd2;
    localparam logic [1:0] REG_HEIGHT      = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [23:0]        az;
        logic signed [15:0] bx;
        logic signed [15:0] by_coord;
        logic [23:0]        bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [23:0]        cz;
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
    } request_t;

    typedef struct packed {
        logic        triangle_kept;
        logic        covered;
        logic        depth_pass;
        logic [23:0] depth;
        logic [16:0] weight_a;
        logic [16:0] weight_b;
        logic [16:0] weight_c;
    } result_t;

    // Divider request: initial partial remainder, dividend bits fed MSB first, divisor, count
    typedef struct packed {
        logic              start;
        logic [REM_W-1:0]  rem_init;
        logic [QUO_W-1:0]  bits;
        logic [REM_W-1:0]  den;
        logic [QCNT_W-1:0] qbits;
    } div_req_t;

    typedef struct packed {
        logic             active;
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

@@ rtl/core/tpcdt_ram.sv @@
// Generic simple dual-port RAM with registered read
module tpcdt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/tpcdt_div.sv @@
// Restoring divider, one quotient bit per cycle
module tpcdt_div (
    input  logic                clk,
    input  logic                rst_n,
    input  tpcdt_pkg::div_req_t req,
    output tpcdt_pkg::div_rsp_t rsp
);

    logic                           active_reg;
    logic                           done_reg;
    logic [tpcdt_pkg::QCNT_W-1:0]   cnt_reg;
    logic [tpcdt_pkg::REM_W-1:0]    rem_reg;
    logic [tpcdt_pkg::REM_W-1:0]    den_reg;
    logic [tpcdt_pkg::QUO_W-1:0]    bits_reg;
    logic [tpcdt_pkg::QUO_W-1:0]    quo_reg;
    logic [tpcdt_pkg::REM_W:0]      trial;
    logic [tpcdt_pkg::REM_W+1:0]    diff;
    logic                           ge;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, bits_reg[tpcdt_pkg::QUO_W-1]};
    assign diff  = {1'b0, trial} - {2'b0, den_reg};
    assign ge    = !diff[tpcdt_pkg::REM_W+1];

    // Control: count the quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !active_reg)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= req.qbits;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tpcdt_pkg::QCNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, dividend stream and quotient
    always_ff @(posedge clk)
    begin
        if (req.start && !active_reg)
        begin
            rem_reg  <= req.rem_init;
            den_reg  <= req.den;
            bits_reg <= req.bits;
            quo_reg  <= '0;
        end
        else if (active_reg)
        begin
            rem_reg  <= ge ? diff[tpcdt_pkg::REM_W-1:0] : trial[tpcdt_pkg::REM_W-1:0];
            bits_reg <= {bits_reg[tpcdt_pkg::QUO_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[tpcdt_pkg::QUO_W-2:0], ge};
        end
    end

    assign rsp.active = active_reg;
    assign rsp.done   = done_reg;
    assign rsp.quo    = quo_reg;

endmodule

@@ rtl/core/triangle_pixel_coverage_depth_test.sv @@
// Edge-function triangle rasteriser pixel test with perspective-correct depth and depth store
//
// Usage: present a command item on request and raise start; it is taken at a rising edge
// where start is high and busy is low. busy stays high until the item's result has been
// produced. Every command gives exactly one result on result, marked by done for one
// cycle; the receiver cannot stall it, so it must sample result whenever done is high.
// Setup latches three vertices, computes the doubled area on the shared multiplier and
// three reciprocal depths on the shared serial divider. A pixel test runs the edge
// products on the shared multiplier, then up to seven divisions of 17 or 24 quotient
// bits on the same divider and a read-modify-write of the depth store. Unused command
// codes, pixels outside the active area and pixels with no kept triangle answer in the
// cycle after they are taken; a pixel outside the edges answers after the edge
// products. A clear command sweeps the depth store one entry a cycle. The block takes
// a new item only once the result of the last one has been produced.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once; issue them
// only while the block is idle. After reset the block sweeps the depth store to maximum
// depth with busy high and gives no result for that sweep.
module triangle_pixel_coverage_depth_test (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tpcdt_pkg::request_t request,
    output logic                done,
    output tpcdt_pkg::result_t  result,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_CLEAR     = 11'b000_0000_0010,
        ST_SET_MUL   = 11'b000_0000_0100,
        ST_SET_DIV   = 11'b000_0000_1000,
        ST_PIX_MUL   = 11'b000_0001_0000,
        ST_PIX_BARY  = 11'b000_0010_0000,
        ST_PIX_TERM  = 11'b000_0100_0000,
        ST_PIX_SUM   = 11'b000_1000_0000,
        ST_PIX_DEPTH = 11'b001_0000_0000,
        ST_PIX_WGT   = 11'b010_0000_0000,
        ST_PIX_TEST  = 11'b100_0000_0000
    } state_t;

    // Control state
    state_t                         state_reg;
    logic [2:0]                     step_reg;
    logic                           div_issued_reg;
    logic [tpcdt_pkg::ADDR_W-1:0]   clr_cnt_reg;
    logic                           clr_report_reg;
    logic                           done_reg;
    tpcdt_pkg::result_t             result_reg;
    logic                           tri_valid_reg;
    logic                           dte_reg;
    logic                           dwe_reg;
    logic [8:0]                     aw_reg;
    logic [8:0]                     ah_reg;

    // Datapath state
    logic signed [15:0]             vx_reg [3];
    logic signed [15:0]             vy_reg [3];
    logic [23:0]                    vz_reg [3];
    logic [tpcdt_pkg::QUO_W-1:0]    recip_reg [3];
    logic signed [35:0]             acc_reg;
    logic signed [35:0]             area_reg;
    logic signed [35:0]             e_reg [3];
    logic [16:0]                    b_reg [3];
    logic [16:0]                    w_reg [3];
    logic [tpcdt_pkg::REM_W-1:0]    t_reg [3];
    logic [tpcdt_pkg::REM_W-1:0]    s_reg;
    logic [23:0]                    z_reg;
    logic [7:0]                     px_reg;
    logic [7:0]                     py_reg;
    logic [tpcdt_pkg::ADDR_W-1:0]   addr_reg;

    // Combinational signals
    logic                           accept;
    logic [8:0]                     wlim;
    logic [8:0]                     hlim;
    logic                           in_bounds;
    logic [tpcdt_pkg::ADDR_W-1:0]   req_addr;
    logic signed [16:0]             ux0, ux1, ux2, uy0, uy1, uy2;
    logic signed [17:0]             pxq, pyq;
    logic signed [17:0]             dx0, dx1, dx2, dy0, dy1, dy2;
    logic signed [24:0]             mul_a;
    logic signed [24:0]             mul_b;
    logic signed [49:0]             mul_p;
    logic signed [35:0]             acc_diff;
    logic                           any_pos;
    logic [1:0]                     idx;
    logic                           odd;
    logic [1:0]                     nidx;
    logic signed [35:0]             n_full;
    logic [34:0]                    n_val;
    logic [34:0]                    d_val;
    logic [tpcdt_pkg::REM_W-1:0]    t_sum;
    logic                           sat;
    logic                           div_state;
    tpcdt_pkg::div_req_t            div_req;
    tpcdt_pkg::div_rsp_t            div_rsp;
    logic                           mem_we;
    logic [tpcdt_pkg::ADDR_W-1:0]   mem_waddr;
    logic [tpcdt_pkg::DEPTH_BITS-1:0] mem_wdata;
    logic                           mem_re;
    logic [tpcdt_pkg::DEPTH_BITS-1:0] mem_rdata;
    logic                           pass;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;
    assign idx    = step_reg[1:0];
    assign odd    = step_reg[0];

    // Active-area limits: the smaller of register and screen size
    assign wlim = (aw_reg > 9'(tpcdt_pkg::MAX_WIDTH)) ? 9'(tpcdt_pkg::MAX_WIDTH) : aw_reg;
    assign hlim = (ah_reg > 9'(tpcdt_pkg::MAX_HEIGHT)) ? 9'(tpcdt_pkg::MAX_HEIGHT) : ah_reg;
    assign in_bounds = ({1'b0, request.pixel_x} < wlim) && ({1'b0, request.pixel_y} < hlim);
    assign req_addr  = tpcdt_pkg::ADDR_W'(request.pixel_y) *
                       tpcdt_pkg::ADDR_W'(tpcdt_pkg::MAX_WIDTH) +
                       tpcdt_pkg::ADDR_W'(request.pixel_x);

    // Edge vectors and pixel offsets
    assign ux0 = 17'(vx_reg[1]) - 17'(vx_reg[0]);
    assign ux1 = 17'(vx_reg[2]) - 17'(vx_reg[1]);
    assign ux2 = 17'(vx_reg[0]) - 17'(vx_reg[2]);
    assign uy0 = 17'(vy_reg[1]) - 17'(vy_reg[0]);
    assign uy1 = 17'(vy_reg[2]) - 17'(vy_reg[1]);
    assign uy2 = 17'(vy_reg[0]) - 17'(vy_reg[2]);
    assign pxq = $signed({6'b0, px_reg, 4'b0});
    assign pyq = $signed({6'b0, py_reg, 4'b0});
    assign dx0 = pxq - 18'(vx_reg[0]);
    assign dx1 = pxq - 18'(vx_reg[1]);
    assign dx2 = pxq - 18'(vx_reg[2]);
    assign dy0 = pyq - 18'(vy_reg[0]);
    assign dy1 = pyq - 18'(vy_reg[1]);
    assign dy2 = pyq - 18'(vy_reg[2]);

    // Select operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SET_MUL:
            begin
                mul_a = odd ? 25'(uy0) : 25'(ux0);
                mul_b = odd ? 25'(ux1) : 25'(uy1);
            end
            ST_PIX_MUL:
            begin
                case (step_reg)
                    3'd0:    begin mul_a = 25'(ux0); mul_b = 25'(dy0); end
                    3'd1:    begin mul_a = 25'(uy0); mul_b = 25'(dx0); end
                    3'd2:    begin mul_a = 25'(ux1); mul_b = 25'(dy1); end
                    3'd3:    begin mul_a = 25'(uy1); mul_b = 25'(dx1); end
                    3'd4:    begin mul_a = 25'(ux2); mul_b = 25'(dy2); end
                    3'd5:    begin mul_a = 25'(uy2); mul_b = 25'(dx2); end
                    default: begin mul_a = '0;       mul_b = '0;       end
                endcase
            end
            ST_PIX_TERM:
            begin
                mul_a = $signed({8'b0, b_reg[step_reg[2:1]]});
                mul_b = odd ? $signed({8'b0, recip_reg[step_reg[2:1]][40:24]})
                            : $signed({1'b0, recip_reg[step_reg[2:1]][23:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign acc_diff = acc_reg - $signed(mul_p[35:0]);
    assign any_pos  = (e_reg[0] > 36'sd0) || (e_reg[1] > 36'sd0) || (acc_diff > 36'sd0);

    // Barycentric numerator of vertex v comes from the edge opposite it
    always_comb
    begin
        case (idx)
            2'd0:    nidx = 2'd1;
            2'd1:    nidx = 2'd2;
            default: nidx = 2'd0;
        endcase
    end

    assign n_full = -e_reg[nidx];
    assign n_val  = n_full[34:0];
    assign d_val  = 35'(-area_reg);
    assign t_sum  = t_reg[0] + t_reg[1] + t_reg[2];
    assign sat    = (s_reg <= (tpcdt_pkg::REM_W'(1) << 32));

    // Build the divider request for the current division
    assign div_state = (state_reg == ST_SET_DIV) || (state_reg == ST_PIX_BARY) ||
                       (state_reg == ST_PIX_DEPTH) || (state_reg == ST_PIX_WGT);

    always_comb
    begin
        div_req.start    = div_state && !div_issued_reg &&
                           !((state_reg == ST_PIX_DEPTH) && sat);
        div_req.rem_init = '0;
        div_req.bits     = '0;
        div_req.den      = tpcdt_pkg::REM_W'(1);
        div_req.qbits    = tpcdt_pkg::QCNT_W'(17);
        case (state_reg)
            ST_SET_DIV:
            begin
                div_req.bits  = {1'b1, 40'b0};
                div_req.den   = (vz_reg[idx] == 24'd0) ? tpcdt_pkg::REM_W'(1)
                                                       : tpcdt_pkg::REM_W'(vz_reg[idx]);
                div_req.qbits = tpcdt_pkg::QCNT_W'(tpcdt_pkg::QUO_W);
            end
            ST_PIX_BARY:
            begin
                div_req.rem_init = tpcdt_pkg::REM_W'(n_val >> 1);
                div_req.bits     = {n_val[0], 40'b0};
                div_req.den      = tpcdt_pkg::REM_W'(d_val);
            end
            ST_PIX_DEPTH:
            begin
                div_req.rem_init = tpcdt_pkg::REM_W'(1) << 32;
                div_req.den      = s_reg;
                div_req.qbits    = tpcdt_pkg::QCNT_W'(24);
            end
            ST_PIX_WGT:
            begin
                div_req.rem_init = t_reg[idx] >> 1;
                div_req.bits     = {t_reg[idx][0], 40'b0};
                div_req.den      = s_reg;
            end
            default:
            begin
                div_req.rem_init = '0;
            end
        endcase
    end

    tpcdt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Depth store: sweep writes while clearing, read-modify-write on a pixel
    assign pass      = !(dte_reg && (mem_rdata < z_reg));
    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_PIX_TEST) && pass && dwe_reg);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? tpcdt_pkg::DEPTH_MAX : z_reg;
    assign mem_re    = accept && (request.command == tpcdt_pkg::CMD_PIXEL);

    tpcdt_ram #(
        .WIDTH (tpcdt_pkg::DEPTH_BITS),
        .DEPTH (tpcdt_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (req_addr),
        .rdata (mem_rdata)
    );

    // Sequencer, configuration and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            step_reg       <= '0;
            div_issued_reg <= 1'b0;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            tri_valid_reg  <= 1'b0;
            dte_reg        <= 1'b1;
            dwe_reg        <= 1'b1;
            aw_reg         <= 9'd256;
            ah_reg         <= 9'd256;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_write)
            begin
                case (cfg_index)
                    tpcdt_pkg::REG_DEPTH_TEST:  dte_reg <= cfg_data[0];
                    tpcdt_pkg::REG_DEPTH_WRITE: dwe_reg <= cfg_data[0];
                    tpcdt_pkg::REG_WIDTH:       aw_reg  <= cfg_data;
                    tpcdt_pkg::REG_HEIGHT:      ah_reg  <= cfg_data;
                    default:                    dte_reg <= dte_reg;
                endcase
            end

            if (div_req.start)
            begin
                div_issued_reg <= 1'b1;
            end
            if (div_rsp.done)
            begin
                div_issued_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        step_reg <= '0;
                        case (request.command)
                            tpcdt_pkg::CMD_SETUP:
                            begin
                                state_reg <= ST_SET_MUL;
                            end
                            tpcdt_pkg::CMD_PIXEL:
                            begin
                                if (tri_valid_reg && in_bounds)
                                begin
                                    state_reg <= ST_PIX_MUL;
                                end
                                else
                                begin
                                    done_reg   <= 1'b1;
                                    result_reg <= '0;
                                end
                            end
                            tpcdt_pkg::CMD_CLEAR:
                            begin
                                state_reg      <= ST_CLEAR;
                                clr_cnt_reg    <= '0;
                                clr_report_reg <= 1'b1;
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '0;
                            end
                        endcase
                    end
                end
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg  <= ST_IDLE;
                        done_reg   <= clr_report_reg;
                        result_reg <= '0;
                    end
                end
                ST_SET_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (odd)
                    begin
                        tri_valid_reg <= (acc_diff < 36'sd0);
                        state_reg     <= ST_SET_DIV;
                        step_reg      <= '0;
                    end
                end
                ST_SET_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == 3'd2)
                        begin
                            state_reg  <= ST_IDLE;
                            done_reg   <= 1'b1;
                            result_reg <= {tri_valid_reg,
                                           {($bits(tpcdt_pkg::result_t)-1){1'b0}}};
                        end
                    end
                end
                ST_PIX_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd5)
                    begin
                        step_reg <= '0;
                        if (any_pos)
                        begin
                            state_reg  <= ST_IDLE;
                            done_reg   <= 1'b1;
                            result_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_PIX_BARY;
                        end
                    end
                end
                ST_PIX_BARY:
                begin
                    if (div_rsp.done)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == 3'd2)
                        begin
                            step_reg  <= '0;
                            state_reg <= ST_PIX_TERM;
                        end
                    end
                end
                ST_PIX_TERM:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd5)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_PIX_SUM;
                    end
                end
                ST_PIX_SUM:
                begin
                    state_reg <= ST_PIX_DEPTH;
                end
                ST_PIX_DEPTH:
                begin
                    if (sat || div_rsp.done)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_PIX_WGT;
                    end
                end
                ST_PIX_WGT:
                begin
                    if (div_rsp.done)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == 3'd2)
                        begin
                            state_reg <= ST_PIX_TEST;
                        end
                    end
                end
                ST_PIX_TEST:
                begin
                    state_reg                <= ST_IDLE;
                    done_reg                 <= 1'b1;
                    result_reg.triangle_kept <= 1'b0;
                    result_reg.covered       <= 1'b1;
                    result_reg.depth_pass    <= pass;
                    result_reg.depth         <= z_reg;
                    result_reg.weight_a      <= w_reg[0];
                    result_reg.weight_b      <= w_reg[1];
                    result_reg.weight_c      <= w_reg[2];
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: latch operands, accumulate products, take quotients
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (request.command == tpcdt_pkg::CMD_SETUP)
            begin
                vx_reg[0] <= request.ax;
                vy_reg[0] <= request.ay;
                vz_reg[0] <= request.az;
                vx_reg[1] <= request.bx;
                vy_reg[1] <= request.by_coord;
                vz_reg[1] <= request.bz;
                vx_reg[2] <= request.cx;
                vy_reg[2] <= request.cy;
                vz_reg[2] <= request.cz;
            end
            px_reg   <= request.pixel_x;
            py_reg   <= request.pixel_y;
            addr_reg <= req_addr;
        end

        case (state_reg)
            ST_SET_MUL:
            begin
                if (odd)
                begin
                    area_reg <= acc_diff;
                end
                else
                begin
                    acc_reg <= mul_p[35:0];
                end
            end
            ST_SET_DIV:
            begin
                if (div_rsp.done)
                begin
                    recip_reg[idx] <= div_rsp.quo;
                end
            end
            ST_PIX_MUL:
            begin
                if (odd)
                begin
                    e_reg[step_reg[2:1]] <= acc_diff;
                end
                else
                begin
                    acc_reg <= mul_p[35:0];
                end
            end
            ST_PIX_BARY:
            begin
                if (div_rsp.done)
                begin
                    b_reg[idx] <= div_rsp.quo[16:0];
                end
            end
            ST_PIX_TERM:
            begin
                if (odd)
                begin
                    t_reg[step_reg[2:1]] <= t_reg[step_reg[2:1]] +
                                            ({24'b0, mul_p[33:0]} << 24);
                end
                else
                begin
                    t_reg[step_reg[2:1]] <= {17'b0, mul_p[40:0]};
                end
            end
            ST_PIX_SUM:
            begin
                s_reg <= (t_sum == '0) ? tpcdt_pkg::REM_W'(1) : t_sum;
            end
            ST_PIX_DEPTH:
            begin
                if (sat)
                begin
                    z_reg <= tpcdt_pkg::DEPTH_MAX;
                end
                else if (div_rsp.done)
                begin
                    z_reg <= div_rsp.quo[23:0];
                end
            end
            ST_PIX_WGT:
            begin
                if (div_rsp.done)
                begin
                    w_reg[idx] <= div_rsp.quo[16:0];
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Divider is never left running once the block is idle
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !div_rsp.active)
        else $error("divider active while idle");

    // A clear command that is taken sets the block busy to start its sweep
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.command == tpcdt_pkg::CMD_CLEAR)) |=> busy)
        else $error("clear command did not start sweep");

    // A drawn pixel is always a covered pixel
    a_pass_cov: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!result.depth_pass || result.covered))
        else $error("depth pass without coverage");

    // Pixel writes to the store only with depth write enabled
    a_write_en: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg != ST_CLEAR)) |-> dwe_reg)
        else $error("store written with depth write disabled");

endmodule
